// File: src/vca_pkg.sv
`default_nettype none
package vca_pkg;

    // Default field widths for price and amount
    localparam int DEF_PRICE_BITS  = 24;
    localparam int DEF_AMOUNT_BITS = 24;

    // Fixed widths of the group identity fields and the running sums
    localparam int KEY_BITS   = 32;
    localparam int PROD_BITS  = 8;
    localparam int VSUM_BITS  = 64;
    localparam int ASUM_BITS  = 40;

endpackage
`default_nettype wire

// File: src/vwap_candle_aggregator.sv
// Sequence: an entry that stays in its group passes S_MUL and S_ACC before ready again.
// An entry that closes a group passes S_MUL, S_DCHK, S_DIV, S_CLOSE and S_ACC, with
// one radix-2 restoring divide step per cycle over the quotient bits; zero volume or a clamped
// average skips the divide. A full output register holds the sequencer in S_CLOSE.
// Throughput: one entry at a time; o_in_stall stays high while an entry is in work.
// Reset: synchronous, active low; clears the sequencer, group state and output valid.
`default_nettype none
module vwap_candle_aggregator
    import vca_pkg::*;
#(
    parameter int PRICE_BITS  = DEF_PRICE_BITS,
    parameter int AMOUNT_BITS = DEF_AMOUNT_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    // Trade entry channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [KEY_BITS-1:0]    i_group_key,
    input  wire logic [PROD_BITS-1:0]   i_product_code,
    input  wire logic                   i_side,
    input  wire logic [PRICE_BITS-1:0]  i_price,
    input  wire logic [AMOUNT_BITS-1:0] i_amount,

    // Candle channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [KEY_BITS-1:0]         o_candle_key,
    output logic [PROD_BITS-1:0]        o_candle_product,
    output logic                        o_candle_side,
    output logic [PRICE_BITS-1:0]       o_high_price,
    output logic [PRICE_BITS-1:0]       o_low_price,
    output logic [PRICE_BITS-1:0]       o_open_price,
    output logic [PRICE_BITS-1:0]       o_close_price,
    output logic                        o_zero_volume,
    output logic                        o_sum_saturated
);

    localparam int PROD_W   = PRICE_BITS + AMOUNT_BITS;
    localparam int CNT_BITS = $clog2(PRICE_BITS + 1);

    // Sequencer: one-hot states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,  // ready for the next transfer
        S_MUL   = 6'b000010,  // form price*amount, decide group change
        S_DCHK  = 6'b000100,  // zero volume and overflow check of the quotient
        S_DIV   = 6'b001000,  // one restoring divide step per cycle
        S_CLOSE = 6'b010000,  // emit candle, start the next group
        S_ACC   = 6'b100000   // fold the entry into the running sums
    } t_state;

    t_state r_state, n_state;

    // Latched entry
    logic [KEY_BITS-1:0]    r_key;
    logic [PROD_BITS-1:0]   r_prod_code;
    logic                   r_side;
    logic [PRICE_BITS-1:0]  r_price;
    logic [AMOUNT_BITS-1:0] r_amount;
    logic [PROD_W-1:0]      r_mul;

    // Group state
    logic                   r_group_open;
    logic                   r_first_group;
    logic [KEY_BITS-1:0]    r_cur_key;
    logic [PROD_BITS-1:0]   r_cur_product;
    logic                   r_cur_side;
    logic [PRICE_BITS-1:0]  r_run_high;
    logic [PRICE_BITS-1:0]  r_run_low;
    logic [PRICE_BITS-1:0]  r_prev_avg;
    logic [VSUM_BITS-1:0]   r_vsum;
    logic [ASUM_BITS-1:0]   r_asum;
    logic                   r_sat;

    // Divider state
    logic [ASUM_BITS-1:0]   r_rem;
    logic [PRICE_BITS-1:0]  r_dvd;
    logic [PRICE_BITS-1:0]  r_quo;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_zero;

    // Output register
    logic                   r_out_valid;
    logic [KEY_BITS-1:0]    r_out_key;
    logic [PROD_BITS-1:0]   r_out_product;
    logic                   r_out_side;
    logic [PRICE_BITS-1:0]  r_out_high;
    logic [PRICE_BITS-1:0]  r_out_low;
    logic [PRICE_BITS-1:0]  r_out_open;
    logic [PRICE_BITS-1:0]  r_out_close;
    logic                   r_out_zero;
    logic                   r_out_sat;

    logic w_in_xfer;
    logic w_out_free;
    logic w_key_change;
    logic w_quo_big;
    logic [ASUM_BITS:0]     w_rem2;
    logic                   w_ge;
    logic [ASUM_BITS:0]     w_diff;
    logic [VSUM_BITS:0]     w_vadd;
    logic [ASUM_BITS:0]     w_aadd;

    assign o_in_stall   = (r_state != S_IDLE);
    assign w_in_xfer    = i_in_valid && !o_in_stall;
    // Output register can take a candle when empty or being drained this cycle
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_key_change = r_group_open && (r_key != r_cur_key);

    // Quotient does not fit the price width when (value >> PRICE_BITS) >= amount
    assign w_quo_big = (r_vsum >> PRICE_BITS) >= VSUM_BITS'(r_asum);

    // Restoring divide step
    assign w_rem2 = {r_rem, r_dvd[PRICE_BITS-1]};
    assign w_ge   = w_rem2 >= {1'b0, r_asum};
    assign w_diff = w_rem2 - {1'b0, r_asum};

    // Saturating accumulate, carry out marks overflow
    assign w_vadd = {1'b0, r_vsum} + {1'b0, VSUM_BITS'(r_mul)};
    assign w_aadd = {1'b0, r_asum} + {1'b0, ASUM_BITS'(r_amount)};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_xfer) n_state = S_MUL;
            S_MUL:   n_state = w_key_change ? S_DCHK : S_ACC;
            S_DCHK: begin
                if (r_asum == '0 || w_quo_big) n_state = S_CLOSE;
                else                           n_state = S_DIV;
            end
            S_DIV:   if (r_cnt == CNT_BITS'(1)) n_state = S_CLOSE;
            S_CLOSE: if (r_first_group || w_out_free) n_state = S_ACC;
            S_ACC:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // Drain the output register on a candle transfer
        if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

        case (r_state)
            S_IDLE: begin
                // Hold the entry for the whole run
                if (w_in_xfer) begin
                    r_key       <= i_group_key;
                    r_prod_code <= i_product_code;
                    r_side      <= i_side;
                    r_price     <= i_price;
                    r_amount    <= i_amount;
                end
            end
            S_MUL: begin
                r_mul <= PROD_W'(r_price) * PROD_W'(r_amount);
                if (!r_group_open) begin
                    // Very first entry opens a group without closing one
                    r_group_open  <= 1'b1;
                    r_cur_key     <= r_key;
                    r_cur_product <= r_prod_code;
                    r_cur_side    <= r_side;
                    r_run_high    <= r_price;
                    r_run_low     <= r_price;
                    r_vsum        <= '0;
                    r_asum        <= '0;
                    r_sat         <= 1'b0;
                end
            end
            S_DCHK: begin
                r_zero <= (r_asum == '0);
                r_rem  <= ASUM_BITS'(r_vsum >> PRICE_BITS);
                r_dvd  <= r_vsum[PRICE_BITS-1:0];
                r_cnt  <= CNT_BITS'(PRICE_BITS);
                if (r_asum == '0)  r_quo <= '0;
                else if (w_quo_big) r_quo <= '1;
            end
            S_DIV: begin
                r_rem <= w_ge ? w_diff[ASUM_BITS-1:0] : w_rem2[ASUM_BITS-1:0];
                r_dvd <= r_dvd << 1;
                r_quo <= {r_quo[PRICE_BITS-2:0], w_ge};
                r_cnt <= r_cnt - CNT_BITS'(1);
            end
            S_CLOSE: begin
                if (r_first_group || w_out_free) begin
                    if (r_first_group) begin
                        r_first_group <= 1'b0;
                    end else begin
                        r_out_valid   <= 1'b1;
                        r_out_key     <= r_cur_key;
                        r_out_product <= r_cur_product;
                        r_out_side    <= r_cur_side;
                        r_out_high    <= r_run_high;
                        r_out_low     <= r_run_low;
                        r_out_open    <= r_prev_avg;
                        r_out_close   <= r_quo;
                        r_out_zero    <= r_zero;
                        r_out_sat     <= r_sat;
                    end
                    // Average becomes the next open; closing entry starts the new group
                    r_prev_avg    <= r_quo;
                    r_cur_key     <= r_key;
                    r_cur_product <= r_prod_code;
                    r_cur_side    <= r_side;
                    r_run_high    <= r_price;
                    r_run_low     <= r_price;
                    r_vsum        <= '0;
                    r_asum        <= '0;
                    r_sat         <= 1'b0;
                end
            end
            S_ACC: begin
                if (w_vadd[VSUM_BITS]) begin
                    r_vsum <= '1;
                end else begin
                    r_vsum <= w_vadd[VSUM_BITS-1:0];
                end
                if (w_aadd[ASUM_BITS]) begin
                    r_asum <= '1;
                end else begin
                    r_asum <= w_aadd[ASUM_BITS-1:0];
                end
                if (w_vadd[VSUM_BITS] || w_aadd[ASUM_BITS]) r_sat <= 1'b1;
                if (r_price > r_run_high) r_run_high <= r_price;
                if (r_price < r_run_low)  r_run_low  <= r_price;
            end
            default: ;
        endcase

        r_state <= n_state;

        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_group_open  <= 1'b0;
            r_first_group <= 1'b1;
            r_cur_key     <= '0;
            r_cur_product <= '0;
            r_cur_side    <= 1'b0;
            r_run_high    <= '0;
            r_run_low     <= '0;
            r_prev_avg    <= '0;
            r_vsum        <= '0;
            r_asum        <= '0;
            r_sat         <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_candle_key     = r_out_key;
    assign o_candle_product = r_out_product;
    assign o_candle_side    = r_out_side;
    assign o_high_price     = r_out_high;
    assign o_low_price      = r_out_low;
    assign o_open_price     = r_out_open;
    assign o_close_price    = r_out_close;
    assign o_zero_volume    = r_out_zero;
    assign o_sum_saturated  = r_out_sat;

endmodule
`default_nettype wire

// File: src/vca_checker.sv
`default_nettype none
module vca_checker
    import vca_pkg::*;
#(
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [PRICE_BITS-1:0] o_high_price,
    input wire logic [PRICE_BITS-1:0] o_low_price,
    input wire logic [PRICE_BITS-1:0] o_close_price,
    input wire logic                  o_zero_volume
);

    // Hold a stalled candle
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_close_price))
        else $error("stalled candle dropped or changed");

    // Go busy after every entry transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("ready right after an entry transfer");

    a_low_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_low_price <= o_high_price)
        else $error("candle low above high");

    a_zero_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_zero_volume |-> o_close_price == '0)
        else $error("zero volume candle with nonzero close");

endmodule

bind vwap_candle_aggregator vca_checker #(.PRICE_BITS(PRICE_BITS)) u_vca_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_high_price  (o_high_price),
    .o_low_price   (o_low_price),
    .o_close_price (o_close_price),
    .o_zero_volume (o_zero_volume)
);
`default_nettype wire

// File: tb/vwap_candle_aggregator_tb.sv
`timescale 1ns / 1ps

module vwap_candle_aggregator_tb;
    import vca_pkg::*;

    localparam int PRICE_W        = DEF_PRICE_BITS;
    localparam int AMOUNT_W       = DEF_AMOUNT_BITS;
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    // Longest quiet stretch of a correct run: a sender gap, a divide and a
    // receiver stall segment. Take it many times over.
    localparam int QUIET_LIMIT    = 2000;
    localparam int SETTLE_CYCLES  = PRICE_W + 16;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_TRADES  = 1530;

    localparam bit [KEY_BITS-1:0]  KEY_TOP    = '1;
    localparam bit [PRICE_W-1:0]   PRICE_TOP  = '1;
    localparam bit [AMOUNT_W-1:0]  AMOUNT_TOP = '1;

    typedef struct packed {
        bit [KEY_BITS-1:0]  key;
        bit [PROD_BITS-1:0] product;
        bit                 side;
        bit [PRICE_W-1:0]   price;
        bit [AMOUNT_W-1:0]  amount;
    } trade_t;

    typedef struct packed {
        bit [KEY_BITS-1:0]  key;
        bit [PROD_BITS-1:0] product;
        bit                 side;
        bit [PRICE_W-1:0]   high;
        bit [PRICE_W-1:0]   low;
        bit [PRICE_W-1:0]   open;
        bit [PRICE_W-1:0]   close;
        bit                 zero_volume;
        bit                 saturated;
    } candle_t;

    // Running picture of the aggregator: current group, last VWAP, and the
    // candles that are due on the output, oldest first.
    class candle_book;
        bit                  in_group;
        bit                  first_group = 1'b1;
        bit [KEY_BITS-1:0]   cur_key;
        bit [PROD_BITS-1:0]  cur_product;
        bit                  cur_side;
        bit [PRICE_W-1:0]    run_high;
        bit [PRICE_W-1:0]    run_low;
        bit [PRICE_W-1:0]    last_vwap;
        bit [VSUM_BITS-1:0]  value_total;
        bit [ASUM_BITS-1:0]  volume_total;
        bit                  sat;
        candle_t             due_candles[$];
        int                  mismatches;
        int                  candles_seen;
        int                  zero_seen;
        int                  sat_seen;

        function void accumulate(trade_t t);
            bit [VSUM_BITS:0] vnext;
            bit [ASUM_BITS:0] anext;
            vnext = t.price;
            vnext = vnext * t.amount;
            vnext = vnext + {1'b0, value_total};
            if (vnext[VSUM_BITS]) begin
                value_total = '1;
                sat = 1'b1;
            end else begin
                value_total = vnext[VSUM_BITS-1:0];
            end
            anext = t.amount;
            anext = anext + {1'b0, volume_total};
            if (anext[ASUM_BITS]) begin
                volume_total = '1;
                sat = 1'b1;
            end else begin
                volume_total = anext[ASUM_BITS-1:0];
            end
            if (t.price > run_high) run_high = t.price;
            if (t.price < run_low) run_low = t.price;
        endfunction

        function void open_group(trade_t t);
            in_group     = 1'b1;
            cur_key      = t.key;
            cur_product  = t.product;
            cur_side     = t.side;
            run_high     = t.price;
            run_low      = t.price;
            value_total  = '0;
            volume_total = '0;
            sat          = 1'b0;
            accumulate(t);
        endfunction

        function void take_trade(trade_t t);
            candle_t            c;
            bit [VSUM_BITS-1:0] quotient;
            bit [PRICE_W-1:0]   vwap;
            bit                 no_volume;
            if (!in_group) begin
                open_group(t);
                return;
            end
            if (t.key == cur_key) begin
                accumulate(t);
                return;
            end
            // Key changed: close the group with its truncated VWAP.
            no_volume = (volume_total == 0);
            quotient  = no_volume ? '0 : value_total / volume_total;
            vwap      = (|quotient[VSUM_BITS-1:PRICE_W]) ? PRICE_TOP : quotient[PRICE_W-1:0];
            if (first_group) begin
                first_group = 1'b0;
            end else begin
                c.key         = cur_key;
                c.product     = cur_product;
                c.side        = cur_side;
                c.high        = run_high;
                c.low         = run_low;
                c.open        = last_vwap;
                c.close       = vwap;
                c.zero_volume = no_volume;
                c.saturated   = sat;
                due_candles   = {due_candles, c};
            end
            last_vwap = vwap;
            open_group(t);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_field(string what, bit [KEY_BITS-1:0] want, bit [KEY_BITS-1:0] got);
            if (want != got)
                report($sformatf("%s expected %0h actual %0h", what, want, got));
        endfunction

        function void match_candle(candle_t got);
            candle_t want;
            candles_seen++;
            if (got.zero_volume) zero_seen++;
            if (got.saturated) sat_seen++;
            if (due_candles.size() == 0) begin
                report($sformatf("candle for key %0h with none due", got.key));
                return;
            end
            want = due_candles.pop_front();
            check_field("key", want.key, got.key);
            check_field("product", want.product, got.product);
            check_field("side", want.side, got.side);
            check_field("high", want.high, got.high);
            check_field("low", want.low, got.low);
            check_field("open", want.open, got.open);
            check_field("close", want.close, got.close);
            check_field("zero_volume", want.zero_volume, got.zero_volume);
            check_field("saturated", want.saturated, got.saturated);
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  out_stall   = 1'b0;
    logic [KEY_BITS-1:0]   in_key      = '0;
    logic [PROD_BITS-1:0]  in_product  = '0;
    logic                  in_side     = 1'b0;
    logic [PRICE_W-1:0]    in_price    = '0;
    logic [AMOUNT_W-1:0]   in_amount   = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [KEY_BITS-1:0]   o_candle_key;
    logic [PROD_BITS-1:0]  o_candle_product;
    logic                  o_candle_side;
    logic [PRICE_W-1:0]    o_high_price;
    logic [PRICE_W-1:0]    o_low_price;
    logic [PRICE_W-1:0]    o_open_price;
    logic [PRICE_W-1:0]    o_close_price;
    logic                  o_zero_volume;
    logic                  o_sum_saturated;

    candle_book            book;
    candle_t               seen_candle;
    int                    trades_sent;
    int                    burst_left;
    int                    quiet_cycles;
    int                    rx_mode;
    int                    rx_left;
    bit [KEY_BITS-1:0]     last_key;
    bit [KEY_BITS-1:0]     prior_key;

    vwap_candle_aggregator #(
        .PRICE_BITS  (PRICE_W),
        .AMOUNT_BITS (AMOUNT_W)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_group_key      (in_key),
        .i_product_code   (in_product),
        .i_side           (in_side),
        .i_price          (in_price),
        .i_amount         (in_amount),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_candle_key     (o_candle_key),
        .o_candle_product (o_candle_product),
        .o_candle_side    (o_candle_side),
        .o_high_price     (o_high_price),
        .o_low_price      (o_low_price),
        .o_open_price     (o_open_price),
        .o_close_price    (o_close_price),
        .o_zero_volume    (o_zero_volume),
        .o_sum_saturated  (o_sum_saturated)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Receiver: pick a stall pattern for a random stretch, then switch.
    // Modes: always ready, coin flip, mostly stalled, toggling.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode   <= $urandom_range(0, 3);
            rx_left   <= $urandom_range(4, 64);
            out_stall <= 1'b0;
        end else begin
            rx_left <= rx_left - 1;
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= ($urandom_range(0, 7) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    // Check every candle transfer against the oldest one due.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            seen_candle.key         = o_candle_key;
            seen_candle.product     = o_candle_product;
            seen_candle.side        = o_candle_side;
            seen_candle.high        = o_high_price;
            seen_candle.low         = o_low_price;
            seen_candle.open        = o_open_price;
            seen_candle.close       = o_close_price;
            seen_candle.zero_volume = o_zero_volume;
            seen_candle.saturated   = o_sum_saturated;
            book.match_candle(seen_candle);
        end
    end

    // Watchdog: end the run if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic trade_t trade_of(bit [KEY_BITS-1:0] key, bit [PROD_BITS-1:0] product,
                                        bit side, bit [PRICE_W-1:0] price,
                                        bit [AMOUNT_W-1:0] amount);
        trade_t t;
        t.key     = key;
        t.product = product;
        t.side    = side;
        t.price   = price;
        t.amount  = amount;
        return t;
    endfunction

    // Price profiles: full range, extremes, a tight band around a base, low ticks.
    function automatic bit [PRICE_W-1:0] pick_price(int mode, bit [PRICE_W-1:0] base);
        case (mode)
            0: return PRICE_W'($urandom);
            1: return $urandom_range(0, 1) ? PRICE_TOP : '0;
            2: return PRICE_W'(base + $urandom_range(0, 63));
            default: return PRICE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Amount profiles: full range, small, all zero, extremes, zero or one.
    function automatic bit [AMOUNT_W-1:0] pick_amount(int mode);
        case (mode)
            0: return AMOUNT_W'($urandom);
            1: return AMOUNT_W'($urandom_range(0, 15));
            2: return '0;
            3: return $urandom_range(0, 1) ? AMOUNT_TOP : '0;
            default: return AMOUNT_W'($urandom_range(0, 1));
        endcase
    endfunction

    // Present one entry and hold it until the block takes it.
    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_trade(input trade_t t);
        in_valid   <= 1'b1;
        in_key     <= t.key;
        in_product <= t.product;
        in_side    <= t.side;
        in_price   <= t.price;
        in_amount  <= t.amount;
        do @(posedge i_clk); while (o_in_stall);
        book.take_trade(t);
        trades_sent++;
        if (t.key != last_key) begin
            prior_key = last_key;
            last_key  = t.key;
        end
    endtask

    // Sender bursts: count down the burst, then idle for a random gap
    // (sometimes none) and start a new burst.
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // Drop valid and hold off until every due candle has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (book.due_candles.size() != 0);
    endtask

    initial begin
        trade_t             t;
        trade_t             directed[$];
        int                 random_sent;
        bit                 paused;
        bit [KEY_BITS-1:0]  gkey;
        bit [KEY_BITS-1:0]  tail_key;
        bit [PRICE_W-1:0]   base;
        int                 glen;
        int                 pmode;
        int                 amode;
        int                 r;

        book = new;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: very first entry opens a silent group, a zero-volume group,
        // field extremes, truncation, key wrap back to zero.
        directed = {directed, trade_of('0, '0, 1'b0, '0, '0)};
        directed = {directed, trade_of('0, 8'hff, 1'b1, PRICE_TOP, AMOUNT_TOP)};
        directed = {directed, trade_of(KEY_TOP, 8'hff, 1'b1, PRICE_TOP, 24'd1)};
        directed = {directed, trade_of(KEY_TOP, '0, 1'b0, '0, AMOUNT_TOP)};
        directed = {directed, trade_of(32'd1, 8'h5a, 1'b0, 24'd5, '0)};
        directed = {directed, trade_of(32'd1, 8'ha5, 1'b1, 24'd7, '0)};
        directed = {directed, trade_of(32'd2, 8'h01, 1'b1, 24'd100, 24'd3)};
        directed = {directed, trade_of(32'd2, 8'h02, 1'b0, 24'd101, 24'd1)};
        directed = {directed, trade_of(32'd2, 8'h03, 1'b0, 24'd102, '0)};
        directed = {directed, trade_of(32'h8000_0000, 8'h80, 1'b0, PRICE_TOP, AMOUNT_TOP)};
        directed = {directed, trade_of(32'h8000_0000, 8'h00, 1'b1, '0, AMOUNT_TOP)};
        directed = {directed, trade_of(32'h7fff_ffff, 8'h7f, 1'b1, 24'h80_0000, 24'h80_0000)};
        directed = {directed, trade_of(32'h7fff_ffff, 8'h7f, 1'b1, 24'd1, 24'd2)};
        directed = {directed, trade_of(32'h7fff_ffff, 8'h7f, 1'b1, 24'd3, 24'd1)};
        directed = {directed, trade_of('0, '0, 1'b0, 24'haa_aaaa, 24'h55_5555)};
        directed = {directed, trade_of(32'h5555_5555, 8'h55, 1'b1, 24'h55_5555, 24'haa_aaaa)};
        directed = {directed, trade_of(32'haaaa_aaaa, 8'haa, 1'b0, 24'd1, 24'd1)};
        directed = {directed, trade_of('0, '0, 1'b0, 24'd1, 24'd1)};
        foreach (directed[i]) begin
            send_trade(directed[i]);
            pace();
        end
        drain();

        // Random groups: mostly fresh keys, some revisits of an older key
        // and some neighbor keys; per-entry product and side vary to show
        // that only the first entry of a group counts.
        random_sent = 0;
        paused      = 1'b0;
        while (random_sent < RANDOM_TRADES) begin
            r = $urandom_range(0, 15);
            if (r == 0)      gkey = prior_key;
            else if (r == 1) gkey = last_key + 1;
            else             gkey = $urandom;
            if (gkey == last_key) gkey = ~gkey;
            glen  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
            pmode = $urandom_range(0, 3);
            amode = $urandom_range(0, 4);
            base  = PRICE_W'($urandom);
            for (int i = 0; i < glen; i++) begin
                t = trade_of(gkey, PROD_BITS'($urandom), 1'($urandom_range(0, 1)),
                             pick_price(pmode, base), pick_amount(amode));
                send_trade(t);
                pace();
                random_sent++;
                // Pause the sender once mid-run until all candles are out.
                if (!paused && random_sent >= RANDOM_TRADES / 2) begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        // Tail: close the last random group, then one short group with a
        // plain average, closed by a final entry.
        tail_key = last_key + 32'h1000;
        send_trade(trade_of(tail_key, 8'h44, 1'b0, 24'd10, 24'd10));
        send_trade(trade_of(tail_key, 8'h44, 1'b0, 24'd20, 24'd10));
        send_trade(trade_of(tail_key + 1, 8'h55, 1'b1, 24'd1, 24'd1));

        // Drain, then give the block time to show any stray candle.
        in_valid <= 1'b0;
        do @(posedge i_clk); while (book.due_candles.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (book.due_candles.size() != 0) begin
            book.report($sformatf("%0d candles never arrived", book.due_candles.size()));
        end

        $display("run covered %0d trades and %0d candles (%0d zero-volume, %0d saturated)",
                 trades_sent, book.candles_seen, book.zero_seen, book.sat_seen);
        $display("mismatches: %0d", book.mismatches);
        if (book.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
src/vca_pkg.sv
src/vwap_candle_aggregator.sv
src/vca_checker.sv
tb/vwap_candle_aggregator_tb.sv
